>>> sv/tkdrs_pkg.sv
// Shared types and constants for the two-key descending record sorter.
`timescale 1ns / 1ps
`default_nettype none
package tkdrs_pkg;

  localparam int MAX_RECORDS_DEF = 16;
  localparam int PRICE_W         = 32;
  localparam int AMOUNT_W        = 32;
  localparam int TAG_W           = 4;

  typedef struct packed {
    logic [PRICE_W-1:0]  price;
    logic [AMOUNT_W-1:0] amount;
    logic [TAG_W-1:0]    tag;
  } rec_t;

  // chain-wide control, at most one of insert or drain per cycle
  typedef struct packed {
    logic insert;
    logic drain;
  } ctl_t;

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } state_t;

endpackage : tkdrs_pkg
`default_nettype wire

>>> sv/tkdrs_cell.sv
// One slot of the sorting chain: holds a record, compares it with the new word.
`timescale 1ns / 1ps
`default_nettype none
module tkdrs_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire tkdrs_pkg::ctl_t ctl,
  input  wire tkdrs_pkg::rec_t new_rec,
  input  wire tkdrs_pkg::rec_t prev_rec,
  input  wire logic          prev_valid,
  input  wire logic          prev_ahead,
  input  wire tkdrs_pkg::rec_t next_rec,
  input  wire logic          next_valid,
  output tkdrs_pkg::rec_t    rec,
  output logic               valid,
  output logic               ahead
);
  import tkdrs_pkg::*;

  rec_t rec_r;
  logic valid_r;

  // held key >= new key; equal keys stay ahead so arrival order is kept
  assign ahead = valid_r &&
                 ((rec_r.price > new_rec.price) ||
                  ((rec_r.price == new_rec.price) && (rec_r.amount >= new_rec.amount)));

  always_ff @(posedge clk) begin
    if (ctl.insert && !ahead) begin
      rec_r <= prev_ahead ? new_rec : prev_rec;
    end else if (ctl.drain) begin
      rec_r <= next_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.insert && !ahead) begin
      valid_r <= prev_ahead ? 1'b1 : prev_valid;
    end else if (ctl.drain) begin
      valid_r <= next_valid;
    end
  end

  assign rec   = rec_r;
  assign valid = valid_r;

endmodule : tkdrs_cell
`default_nettype wire

>>> sv/two_key_descending_record_sorter.sv
// Top level: insertion chain of record cells with fill/drain control.
// A word is placed in the chain in the cycle it is taken; the first sorted
// word appears in the cycle after the word marked last is taken.
// One input word per cycle while filling; while draining, each accepted output word
// shifts the chain by one record, and the input is stalled throughout draining.
// Reset clears all slot valid bits and returns control to filling; record data is not reset.
`timescale 1ns / 1ps
`default_nettype none
module two_key_descending_record_sorter #(
  parameter int MAX_RECORDS = tkdrs_pkg::MAX_RECORDS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [tkdrs_pkg::PRICE_W-1:0]   in_price,
  input  wire logic [tkdrs_pkg::AMOUNT_W-1:0]  in_amount,
  input  wire logic [tkdrs_pkg::TAG_W-1:0]     in_tag,
  input  wire logic                            in_last_in,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [tkdrs_pkg::PRICE_W-1:0]        out_price,
  output logic [tkdrs_pkg::AMOUNT_W-1:0]       out_amount,
  output logic [tkdrs_pkg::TAG_W-1:0]          out_tag,
  output logic                                 out_last_out
);
  import tkdrs_pkg::*;

  state_t state_r, state_nxt;
  ctl_t   ctl;
  rec_t   new_rec;
  rec_t   cell_rec   [MAX_RECORDS];
  logic   cell_valid [MAX_RECORDS];
  logic   cell_ahead [MAX_RECORDS];
  logic   in_acc, out_acc;

  assign new_rec.price  = in_price;
  assign new_rec.amount = in_amount;
  assign new_rec.tag    = in_tag;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FILL;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_FILL: begin
        if (in_acc && in_last_in) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (out_acc && !cell_valid[1]) state_nxt = ST_FILL;
      end
      default: state_nxt = ST_FILL;
    endcase
  end

  always_comb begin
    in_stall   = 1'b0;
    out_valid  = 1'b0;
    ctl.insert = 1'b0;
    ctl.drain  = 1'b0;
    unique case (state_r)
      ST_FILL: begin
        // input is never stalled while filling; a word arriving on a full chain is dropped
        ctl.insert = in_valid && !cell_valid[MAX_RECORDS-1];
      end
      ST_DRAIN: begin
        in_stall  = 1'b1;
        out_valid = cell_valid[0];
        ctl.drain = out_acc;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    rec_t prev_rec, next_rec;
    logic prev_valid, prev_ahead, next_valid;

    if (i == 0) begin : g_head
      assign prev_rec   = new_rec;
      assign prev_valid = 1'b1;
      assign prev_ahead = 1'b1;
    end else begin : g_body
      assign prev_rec   = cell_rec[i-1];
      assign prev_valid = cell_valid[i-1];
      assign prev_ahead = cell_ahead[i-1];
    end

    if (i == MAX_RECORDS - 1) begin : g_tail
      assign next_rec   = cell_rec[i];
      assign next_valid = 1'b0;
    end else begin : g_mid
      assign next_rec   = cell_rec[i+1];
      assign next_valid = cell_valid[i+1];
    end

    tkdrs_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .new_rec    (new_rec),
      .prev_rec   (prev_rec),
      .prev_valid (prev_valid),
      .prev_ahead (prev_ahead),
      .next_rec   (next_rec),
      .next_valid (next_valid),
      .rec        (cell_rec[i]),
      .valid      (cell_valid[i]),
      .ahead      (cell_ahead[i])
    );
  end

  assign out_price    = cell_rec[0].price;
  assign out_amount   = cell_rec[0].amount;
  assign out_tag      = cell_rec[0].tag;
  assign out_last_out = !cell_valid[1];

endmodule : two_key_descending_record_sorter
`default_nettype wire
